@@ rtl/dgnl_pkg.sv @@
// ----------------------------------------------------------------------------
// dgnl_pkg
// Shared types and constants of the digit grid neighbor linker.
// ----------------------------------------------------------------------------
package dgnl_pkg;

  localparam int POS_W   = 13;
  localparam int PITCH_W = 10;
  localparam int COUNT_W = 7;
  localparam int DIGIT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int TDATA_W    = 40;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH        = 3'd4;

  localparam logic [COUNT_W-1:0] RST_GRID_COLUMNS = 7'd26;
  localparam logic [COUNT_W-1:0] RST_GRID_ROWS    = 7'd15;
  localparam logic [POS_W-1:0]   RST_FIRST_X      = 13'd47;
  localparam logic [POS_W-1:0]   RST_FIRST_Y      = 13'd64;
  localparam logic [PITCH_W-1:0] RST_PITCH        = 10'd48;

  typedef struct packed {
    logic [COUNT_W-1:0] grid_columns;
    logic [COUNT_W-1:0] grid_rows;
    logic [POS_W-1:0]   first_x_half_px;
    logic [POS_W-1:0]   first_y_half_px;
    logic [PITCH_W-1:0] pitch_half_px;
  } cfg_t;

  typedef struct packed {
    logic                grid_full;
    logic                link_above_left;
    logic                link_above_right;
    logic                link_above;
    logic                link_left;
    logic [POS_W-1:0]    center_y;
    logic [POS_W-1:0]    center_x;
    logic [DIGIT_W-1:0]  digit;
  } result_t;

endpackage

@@ rtl/dgnl_ram.sv @@
// ----------------------------------------------------------------------------
// dgnl_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dgnl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ rtl/dgnl_cfg.sv @@
// ----------------------------------------------------------------------------
// dgnl_cfg
// Configuration register file; also shows the value after a pending write.
// ----------------------------------------------------------------------------
module dgnl_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [dgnl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dgnl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dgnl_pkg::cfg_t                   cfg,
  output dgnl_pkg::cfg_t                   cfg_next
);

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      unique case (cfg_index)
        dgnl_pkg::REG_GRID_COLUMNS: cfg_next.grid_columns    = cfg_data[6:0];
        dgnl_pkg::REG_GRID_ROWS:    cfg_next.grid_rows       = cfg_data[6:0];
        dgnl_pkg::REG_FIRST_X:      cfg_next.first_x_half_px = cfg_data;
        dgnl_pkg::REG_FIRST_Y:      cfg_next.first_y_half_px = cfg_data;
        dgnl_pkg::REG_PITCH:        cfg_next.pitch_half_px   = cfg_data[9:0];
        default: ;
      endcase
    end
    if (rst) begin
      cfg_next.grid_columns    = dgnl_pkg::RST_GRID_COLUMNS;
      cfg_next.grid_rows       = dgnl_pkg::RST_GRID_ROWS;
      cfg_next.first_x_half_px = dgnl_pkg::RST_FIRST_X;
      cfg_next.first_y_half_px = dgnl_pkg::RST_FIRST_Y;
      cfg_next.pitch_half_px   = dgnl_pkg::RST_PITCH;
    end
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

endmodule

@@ rtl/dgnl_core.sv @@
// ----------------------------------------------------------------------------
// dgnl_core
// Grid position, center arithmetic, line buffer and neighbor compares.
// ----------------------------------------------------------------------------
module dgnl_core #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dgnl_pkg::cfg_t       cfg,
  input  dgnl_pkg::cfg_t       cfg_next,
  input  logic                 in_accept,
  input  logic [7:0]           in_byte,
  output logic                 res_valid,
  output dgnl_pkg::result_t    res
);

  localparam int IDX_W  = $clog2(MAX_COLUMNS);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int MX_W   = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;
  localparam int CMP_W  = (MX_W > dgnl_pkg::COUNT_W) ? MX_W : dgnl_pkg::COUNT_W;
  localparam logic [CMP_W-1:0] COL_LIM = CMP_W'(MAX_COLUMNS);
  localparam logic [CMP_W-1:0] ROW_LIM = CMP_W'(MAX_ROWS);
  localparam int DW = dgnl_pkg::DIGIT_W;
  localparam int PW = dgnl_pkg::POS_W;

  function automatic logic [CMP_W-1:0] clamp_count(input logic [dgnl_pkg::COUNT_W-1:0] v,
                                                   input logic [CMP_W-1:0] lim);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve == '0) begin
      return CMP_W'(1);
    end else if (ve > lim) begin
      return lim;
    end
    return ve;
  endfunction

  function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] a,
                                            input logic [dgnl_pkg::PITCH_W-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + (PW + 1)'(b);
    return s[PW] ? dgnl_pkg::POS_MAX : s[PW-1:0];
  endfunction

  logic [CNT_W-1:0]  col_count, col_count_next;
  logic [RCNT_W-1:0] row_count, row_count_next;
  logic [PW-1:0]     x_acc, x_acc_next, y_acc, y_acc_next;
  logic              finished, finished_next;
  logic [DW-1:0]     last_digit, last_digit_next;
  logic [DW-1:0]     last_above, last_above_next;
  logic              hit0, hit1;
  logic [DW-1:0]     wd_q;

  logic [CMP_W-1:0]  cols_e, rows_e, cols_n;
  logic              wrap, over, is_digit, take, emit, full;
  logic [CNT_W-1:0]  c, c_n;
  logic [RCNT_W-1:0] r;
  logic [DW-1:0]     d, above_v, ar_v, rd0, rd1;
  logic [PW-1:0]     x, y;
  logic [IDX_W-1:0]  waddr, raddr0, raddr1;

  always_comb begin
    cols_e   = clamp_count(cfg.grid_columns, COL_LIM);
    rows_e   = clamp_count(cfg.grid_rows, ROW_LIM);
    is_digit = (in_byte >= dgnl_pkg::CHAR_ZERO) && (in_byte <= dgnl_pkg::CHAR_NINE);
    wrap     = CMP_W'(col_count) >= cols_e;
    c        = wrap ? '0 : col_count;
    r        = wrap ? row_count + RCNT_W'(1) : row_count;
    over     = CMP_W'(r) >= rows_e;
    take     = in_accept && !finished && is_digit;
    emit     = take && !over;
    d        = DW'(in_byte - dgnl_pkg::CHAR_ZERO);
    above_v  = hit0 ? wd_q : rd0;
    ar_v     = hit1 ? wd_q : rd1;
    full     = (CMP_W'(c) + CMP_W'(1) >= cols_e) && (CMP_W'(r) + CMP_W'(1) >= rows_e);

    if (c == '0) begin
      x = cfg.first_x_half_px;
      y = (r == '0) ? cfg.first_y_half_px : sat_add(y_acc, cfg.pitch_half_px);
    end else begin
      x = sat_add(x_acc, cfg.pitch_half_px);
      y = y_acc;
    end

    res.digit            = d;
    res.center_x         = x;
    res.center_y         = y;
    res.link_left        = (c != '0) && (last_digit == d);
    res.link_above       = (r != '0) && (above_v == d);
    res.link_above_right = (r != '0) && (CMP_W'(c) + CMP_W'(1) < cols_e) && (ar_v == d);
    res.link_above_left  = (r != '0) && (c != '0) && (last_above == d);
    res.grid_full        = full;
    res_valid            = emit;

    col_count_next  = col_count;
    row_count_next  = row_count;
    x_acc_next      = x_acc;
    y_acc_next      = y_acc;
    finished_next   = finished;
    last_digit_next = last_digit;
    last_above_next = last_above;
    if (take) begin
      row_count_next = r;
      if (over) begin
        col_count_next = c;
        finished_next  = 1'b1;
      end else begin
        col_count_next  = c + CNT_W'(1);
        x_acc_next      = x;
        y_acc_next      = y;
        finished_next   = full;
        last_digit_next = d;
        last_above_next = above_v;
      end
    end
    if (rst) begin
      col_count_next = '0;
      row_count_next = '0;
      x_acc_next     = dgnl_pkg::RST_FIRST_X;
      y_acc_next     = dgnl_pkg::RST_FIRST_Y;
      finished_next  = 1'b0;
    end

    // The line buffer is read ahead for the cell that the next digit will fill.
    cols_n = clamp_count(cfg_next.grid_columns, COL_LIM);
    c_n    = (CMP_W'(col_count_next) >= cols_n) ? '0 : col_count_next;
    raddr0 = c_n[IDX_W-1:0];
    raddr1 = IDX_W'(c_n + CNT_W'(1));
    waddr  = c[IDX_W-1:0];
  end

  dgnl_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_COLUMNS)
  ) u_line (
    .clk    (clk),
    .we     (emit),
    .waddr  (waddr),
    .wdata  (d),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_ff @(posedge clk) begin
    col_count  <= col_count_next;
    row_count  <= row_count_next;
    x_acc      <= x_acc_next;
    y_acc      <= y_acc_next;
    finished   <= finished_next;
    last_digit <= last_digit_next;
    last_above <= last_above_next;
    hit0       <= emit && (raddr0 == waddr);
    hit1       <= emit && (raddr1 == waddr);
    wd_q       <= d;
  end

endmodule

@@ rtl/digit_grid_neighbor_linker.sv @@
// ----------------------------------------------------------------------------
// digit_grid_neighbor_linker
// Places stream digits on a grid and flags equal neighbors of each cell.
// ----------------------------------------------------------------------------
// Bytes enter on the s_ group; each accepted word carries one character.
// Characters other than '0' to '9' are dropped. Every digit fills the next
// grid cell in raster order and yields one word on the m_ group with the
// digit, the cell center in half pixels and four neighbor flags; tlast
// marks the last cell of the grid, after which all input is dropped.
// The cfg group writes the five grid registers; write it only while idle.
// The result word is registered and appears in the cycle after its byte
// is accepted, and one byte is taken every cycle while the receiver does
// not stall. The line buffer RAM is read ahead for the next cell, so
// its two registered read ports and the center adder keep that rate.
// A stalled receiver holds the result in the output register; s_tready
// stays high while that register is free or being emptied.
// Reset (rst, synchronous) loads the register defaults and restarts the
// grid at its first cell; the line buffer contents are not cleared.
// ----------------------------------------------------------------------------
module digit_grid_neighbor_linker #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // in_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // digit, center_x, center_y, link_left, link_above, link_above_right,
  // link_above_left, zero fill
  output logic [dgnl_pkg::TDATA_W-1:0]     m_tdata,
  output logic                             m_tlast,   // grid_full
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dgnl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dgnl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dgnl_pkg::cfg_t    cfg, cfg_next;
  dgnl_pkg::result_t res;
  logic              res_valid;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;

  dgnl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_next  (cfg_next)
  );

  dgnl_core #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_next  (cfg_next),
    .in_accept (s_tvalid && s_tready),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid) begin
      m_tdata <= dgnl_pkg::TDATA_W'(res[$bits(res)-2:0]);
      m_tlast <= res.grid_full;
    end
  end

endmodule

@@ rtl/dgnl_checker.sv @@
// ----------------------------------------------------------------------------
// dgnl_checker
// Port-level checks of the digit grid neighbor linker.
// ----------------------------------------------------------------------------
module dgnl_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [7:0]                       s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [dgnl_pkg::TDATA_W-1:0]     m_tdata,
  input logic                             m_tlast
);

  logic s_acc, s_digit;

  assign s_acc   = s_tvalid && s_tready;
  assign s_digit = (s_tdata >= dgnl_pkg::CHAR_ZERO) && (s_tdata <= dgnl_pkg::CHAR_NINE);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result word changed");

  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("result word after the last cell of the grid");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    s_acc && !s_digit && (!m_tvalid || m_tready) |=> !m_tvalid)
    else $error("result word from a non-digit byte");

  a_digit: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_digit |=> !m_tvalid || (m_tdata[3:0] == $past(s_tdata[3:0])))
    else $error("result digit differs from the accepted byte");

endmodule

bind digit_grid_neighbor_linker dgnl_checker u_dgnl_checker (.*);
